// ===== rtl/cdh3d_pkg.sv =====
package cdh3d_pkg;

    localparam int ADDR_BITS  = 16;
    localparam int COUNT_BITS = 16;
    localparam int DEPTH      = 1 << ADDR_BITS;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [2:0] CFG_GRID_W = 3'd0;
    localparam logic [2:0] CFG_GRID_H = 3'd1;
    localparam logic [2:0] CFG_GRID_D = 3'd2;
    localparam logic [2:0] CFG_SRC_X  = 3'd3;
    localparam logic [2:0] CFG_SRC_Y  = 3'd4;
    localparam logic [2:0] CFG_SRC_Z  = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        cell_active;
        logic [15:0] box_min_x;
        logic [15:0] box_min_y;
        logic [15:0] box_min_z;
        logic [15:0] box_max_x;
        logic [15:0] box_max_y;
        logic [15:0] box_max_z;
        logic [15:0] voxel_index;
    } in_item_t;

    typedef struct packed {
        logic [15:0] bin_index;
        logic [15:0] bin_count;
        logic [15:0] peak_count;
        logic [16:0] normalized_value;
        logic        bin_was_hit;
    } out_item_t;

endpackage

// ===== rtl/cdh3d_ram.sv =====
module cdh3d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/cdh3d_divider.sv =====
// Restoring divider, one quotient bit per cycle: quo = num / den.
module cdh3d_divider
    import cdh3d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] num,
    input  logic [16:0] den,
    output logic        done,
    output logic [32:0] quo
);

    logic [32:0] quo_reg, quo_next;
    logic [17:0] rem_reg, rem_next;
    logic [16:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;
    logic [17:0] diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[16:0], quo_reg[32]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                rem_next = diff;
                quo_next = {quo_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/centroid_density_histogram_3d_top.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------
// in       | in_valid / in_ready       | in_data   (in_item_t)
// out      | out_valid / out_ready     | out_data  (out_item_t)
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item is worked at a time on one shared bit-serial divider; in_ready is high only in
// the idle state. A division is a start step, 33 divider steps and a step to see done.
// An add inside storage runs three coordinate divisions, two index steps, a memory
// read-modify-write and a normalize division; an add beyond storage ends after indexing;
// a read runs a memory read and a normalize division (none when the peak is zero); an
// inactive add or the unused code goes straight to output; a clear walks all 65536 bins
// one per cycle. After reset the same sweep runs before in_ready rises, with no result.
// A finished result moves into the output register, so the next input is taken while it
// waits; the following result then stalls in the output state until that transfer.
module centroid_density_histogram_3d_top
    import cdh3d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_DIV_START, S_DIV_WAIT, S_INDEX, S_MUL,
        S_MEM_RD, S_MEM_WAIT, S_UPDATE, S_NORM_START, S_NORM_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [8:0]  gw_reg, gh_reg, gd_reg;
    logic [15:0] sx_reg, sy_reg, sz_reg;
    logic [15:0] peak_reg;
    logic [ADDR_BITS-1:0] sweep_reg;
    logic        sweep_reply_reg;
    in_item_t    item_reg;
    out_item_t   out_reg;
    out_item_t   result_reg;
    logic        out_valid_reg;
    logic [1:0]  axis_reg;
    logic [8:0]  cx_reg, cy_reg, cz_reg;
    logic [31:0] lin_reg;
    logic [15:0] cnt_reg;

    logic        div_start;
    logic [32:0] div_num;
    logic [16:0] div_den;
    logic        div_done;
    logic [32:0] div_quo;

    logic        ram_we;
    logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

    // Effective dimensions and sources for the axis under work.
    logic [8:0]  dim_sel;
    logic [15:0] src_sel, lo_sel, hi_sel;
    logic [8:0]  dim_w, dim_h, dim_d;
    logic [8:0]  clamp_c;

    function automatic logic [8:0] eff_dim(input logic [8:0] r);
        if (r == 9'd0)
        begin
            return 9'd1;
        end
        if (r > 9'd256)
        begin
            return 9'd256;
        end
        return r;
    endfunction

    assign dim_w = eff_dim(gw_reg);
    assign dim_h = eff_dim(gh_reg);
    assign dim_d = eff_dim(gd_reg);

    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                dim_sel = dim_w; src_sel = sx_reg;
                lo_sel = item_reg.box_min_x; hi_sel = item_reg.box_max_x;
            end
            2'd1:
            begin
                dim_sel = dim_h; src_sel = sy_reg;
                lo_sel = item_reg.box_min_y; hi_sel = item_reg.box_max_y;
            end
            default:
            begin
                dim_sel = dim_d; src_sel = sz_reg;
                lo_sel = item_reg.box_min_z; hi_sel = item_reg.box_max_z;
            end
        endcase
    end

    // The quotient is clamped to dim-1 as it comes out of the divider.
    assign clamp_c = (div_quo >= {24'd0, dim_sel}) ? dim_sel - 9'd1 : div_quo[8:0];

    cdh3d_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    cdh3d_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [15:0] new_cnt;
    assign new_cnt = (ram_rdata == 16'hFFFF) ? ram_rdata : ram_rdata + 16'd1;

    always_comb
    begin
        div_start = (state_reg == S_DIV_START) || (state_reg == S_NORM_START);
        if (axis_reg == 2'd3)
        begin
            div_num = {1'b0, cnt_reg, 16'd0};
            div_den = {1'b0, peak_reg};
        end
        else
        begin
            div_num = 33'({17'd0, 16'(lo_sel)} + 33'(hi_sel)) * 33'(dim_sel);
            div_den = {src_sel == 16'd0 ? 16'd1 : src_sel, 1'b0};
        end
        // Bar the sweep, only an add writes its bin back; a read leaves the memory alone.
        ram_we    = (state_reg == S_SWEEP) ||
                    (state_reg == S_UPDATE && item_reg.req_type == REQ_ADD &&
                     lin_reg < 32'(DEPTH));
        ram_waddr = (state_reg == S_SWEEP) ? sweep_reg : lin_reg[ADDR_BITS-1:0];
        ram_wdata = (state_reg == S_SWEEP) ? '0 : new_cnt;
        ram_raddr = lin_reg[ADDR_BITS-1:0];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            sweep_reg       <= '0;
            sweep_reply_reg <= 1'b0;
            peak_reg        <= '0;
            out_valid_reg   <= 1'b0;
            axis_reg        <= '0;
            gw_reg <= 9'd64; gh_reg <= 9'd64; gd_reg <= 9'd16;
            sx_reg <= 16'd1024; sy_reg <= 16'd1024; sz_reg <= 16'd256;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GRID_W: gw_reg <= cfg_data[8:0];
                    CFG_GRID_H: gh_reg <= cfg_data[8:0];
                    CFG_GRID_D: gd_reg <= cfg_data[8:0];
                    CFG_SRC_X:  sx_reg <= cfg_data;
                    CFG_SRC_Y:  sy_reg <= cfg_data;
                    CFG_SRC_Z:  sz_reg <= cfg_data;
                    default: ;
                endcase
            end
            // The output register is loaded when it is empty or its transfer happens now.
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == '1)
                    begin
                        // The sweep after reset gives no result; a clear does.
                        state_reg <= sweep_reply_reg ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_reg <= in_data;
                        out_reg  <= '0;
                        axis_reg <= 2'd0;
                        case (in_data.req_type)
                            REQ_CLEAR:
                            begin
                                peak_reg        <= '0;
                                sweep_reg       <= '0;
                                sweep_reply_reg <= 1'b1;
                                state_reg       <= S_SWEEP;
                            end
                            REQ_ADD:
                            begin
                                if (in_data.cell_active)
                                begin
                                    state_reg <= S_DIV_START;
                                end
                                else
                                begin
                                    out_reg.peak_count <= peak_reg;
                                    state_reg <= S_OUT;
                                end
                            end
                            REQ_READ:
                            begin
                                lin_reg   <= {16'd0, in_data.voxel_index};
                                out_reg.bin_index  <= in_data.voxel_index;
                                out_reg.peak_count <= peak_reg;
                                state_reg <= S_MEM_RD;
                            end
                            default:
                            begin
                                out_reg.peak_count <= peak_reg;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_DIV_START: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        case (axis_reg)
                            2'd0:
                            begin
                                cx_reg <= clamp_c; axis_reg <= 2'd1; state_reg <= S_DIV_START;
                            end
                            2'd1:
                            begin
                                cy_reg <= clamp_c; axis_reg <= 2'd2; state_reg <= S_DIV_START;
                            end
                            2'd2:
                            begin
                                cz_reg <= clamp_c; state_reg <= S_INDEX;
                            end
                            default:
                            begin
                                out_reg.normalized_value <= (div_quo > 33'd65536) ?
                                    17'd65536 : div_quo[16:0];
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_INDEX:
                begin
                    // First product: z*h + y, then times w plus x in the next step.
                    lin_reg   <= 32'(cz_reg) * 32'(dim_h) + 32'(cy_reg);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    lin_reg   <= lin_reg * 32'(dim_w) + 32'(cx_reg);
                    state_reg <= S_MEM_RD;
                end
                S_MEM_RD:
                begin
                    out_reg.bin_index <= lin_reg[15:0];
                    if (lin_reg >= 32'(DEPTH))
                    begin
                        out_reg.peak_count <= peak_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_MEM_WAIT;
                    end
                end
                S_MEM_WAIT: state_reg <= S_UPDATE;
                S_UPDATE:
                begin
                    axis_reg <= 2'd3;
                    if (item_reg.req_type == REQ_ADD)
                    begin
                        cnt_reg <= new_cnt;
                        out_reg.bin_count   <= new_cnt;
                        out_reg.bin_was_hit <= 1'b1;
                        if (new_cnt > peak_reg)
                        begin
                            peak_reg <= new_cnt;
                            out_reg.peak_count <= new_cnt;
                        end
                        else
                        begin
                            out_reg.peak_count <= peak_reg;
                        end
                        // A hit bin is at least 1, so the peak is never zero here.
                        state_reg <= S_NORM_START;
                    end
                    else
                    begin
                        cnt_reg <= ram_rdata;
                        out_reg.bin_count <= ram_rdata;
                        state_reg <= (peak_reg == 16'd0) ? S_OUT : S_NORM_START;
                    end
                end
                S_NORM_START: state_reg <= S_DIV_WAIT;
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        result_reg <= out_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== test/centroid_density_histogram_3d_top_test.sv =====
module centroid_density_histogram_3d_top_test;
    import cdh3d_pkg::*;

    // Clock, reset and the three channels of the block.
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    centroid_density_histogram_3d_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The block is slow: an add runs four divisions and a clear sweeps all
    // 65536 bins. The clear sweep after reset is the longest silent stretch,
    // so the watchdog limit covers it several times over.
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_OFF       = 2000;
    localparam int RANDOM_ITEMS   = 1680;

    // Shadow of the histogram kept by the predictor.
    logic [15:0] shadow_bins [DEPTH];
    logic [15:0] shadow_peak;
    logic [8:0]  shadow_grid [3];
    logic [15:0] shadow_src  [3];

    out_item_t   expected_results [$];
    int          error_count;
    int          idle_cycles;
    bit          stimulus_done;

    // Percentages of idling for the sender and the receiver, changed by phase.
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          recv_hold;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] effective_dim(input logic [8:0] r);
        if (r == 9'd0)
            return 64'd1;
        if (r > 9'd256)
            return 64'd256;
        return {55'd0, r};
    endfunction

    // Maps a box centre on one axis to its grid coordinate.
    function automatic logic [63:0] centre_coord(input logic [15:0] lo, input logic [15:0] hi,
                                                 input logic [63:0] dim, input logic [15:0] src);
        logic [63:0] s;
        logic [63:0] c;
        s = (src == 16'd0) ? 64'd1 : {48'd0, src};
        c = (({48'd0, lo} + {48'd0, hi}) * dim) / (64'd2 * s);
        return (c > dim - 64'd1) ? dim - 64'd1 : c;
    endfunction

    function automatic logic [16:0] density_of(input logic [15:0] cnt);
        logic [63:0] q;
        if (shadow_peak == 16'd0)
            return 17'd0;
        q = ({48'd0, cnt} << 16) / {48'd0, shadow_peak};
        return (q > 64'd65536) ? 17'd65536 : q[16:0];
    endfunction

    // Advances the histogram shadow by one request and returns its result.
    function automatic out_item_t histogram_step(input in_item_t req);
        out_item_t   r;
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] d;
        logic [63:0] lin;
        logic [15:0] c;
        r = '0;
        case (req.req_type)
            REQ_CLEAR:
            begin
                foreach (shadow_bins[i])
                    shadow_bins[i] = 16'd0;
                shadow_peak = 16'd0;
            end
            REQ_ADD:
            begin
                if (req.cell_active)
                begin
                    w = effective_dim(shadow_grid[0]);
                    h = effective_dim(shadow_grid[1]);
                    d = effective_dim(shadow_grid[2]);
                    lin = centre_coord(req.box_min_z, req.box_max_z, d, shadow_src[2]) * w * h
                        + centre_coord(req.box_min_y, req.box_max_y, h, shadow_src[1]) * w
                        + centre_coord(req.box_min_x, req.box_max_x, w, shadow_src[0]);
                    r.bin_index = lin[15:0];
                    if (lin < DEPTH)
                    begin
                        c = shadow_bins[lin[15:0]];
                        if (c != 16'hFFFF)
                            c = c + 16'd1;
                        shadow_bins[lin[15:0]] = c;
                        if (c > shadow_peak)
                            shadow_peak = c;
                        r.bin_count = c;
                        r.normalized_value = density_of(c);
                        r.bin_was_hit = 1'b1;
                    end
                end
                r.peak_count = shadow_peak;
            end
            REQ_READ:
            begin
                r.bin_index = req.voxel_index;
                r.bin_count = shadow_bins[req.voxel_index];
                r.normalized_value = density_of(r.bin_count);
                r.peak_count = shadow_peak;
            end
            default:
                r.peak_count = shadow_peak;
        endcase
        return r;
    endfunction

    // Sends one request; the input changes only at the falling edge. Valid stays
    // high after the transfer until the next falling edge sets up the next request.
    task automatic send_request(input in_item_t req);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(histogram_step(req));
    endtask

    // Drops valid after the last request of a run.
    task automatic release_input;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Writes one register; the testbench calls it only while the block is idle.
    task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx <= CFG_GRID_D)
            shadow_grid[idx[1:0]] = value[8:0];
        else
            shadow_src[2'(idx - CFG_SRC_X)] = value;
    endtask

    task automatic wait_drained;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_geometry(input logic [15:0] gw, input logic [15:0] gh,
                                input logic [15:0] gd, input logic [15:0] sx,
                                input logic [15:0] sy, input logic [15:0] sz);
        wait_drained();
        write_register(CFG_GRID_W, gw);
        write_register(CFG_GRID_H, gh);
        write_register(CFG_GRID_D, gd);
        write_register(CFG_SRC_X, sx);
        write_register(CFG_SRC_Y, sy);
        write_register(CFG_SRC_Z, sz);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t make_request(input logic [1:0] kind, input logic act,
                                              input logic [15:0] mnx, input logic [15:0] mny,
                                              input logic [15:0] mnz, input logic [15:0] mxx,
                                              input logic [15:0] mxy, input logic [15:0] mxz,
                                              input logic [15:0] vox);
        in_item_t r;
        r.req_type    = kind;
        r.cell_active = act;
        r.box_min_x   = mnx;
        r.box_min_y   = mny;
        r.box_min_z   = mnz;
        r.box_max_x   = mxx;
        r.box_max_y   = mxy;
        r.box_max_z   = mxz;
        r.voxel_index = vox;
        return r;
    endfunction

    // Random request with content scaled to the current source extents so that
    // most adds land inside the grid; a share uses wild corners.
    function automatic in_item_t random_request();
        in_item_t     r;
        logic [127:0] raw;
        int           pick;
        raw = {$urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(in_item_t)-1:0];
        pick = $urandom_range(99);
        if (pick < 3)
            r.req_type = REQ_CLEAR;
        else if (pick < 65)
            r.req_type = REQ_ADD;
        else if (pick < 97)
            r.req_type = REQ_READ;
        else
            r.req_type = 2'd3;
        if ($urandom_range(9) != 0)
            r.cell_active = 1'b1;
        if ($urandom_range(4) != 0)
        begin
            r.box_min_x = 16'($urandom_range(shadow_src[0]));
            r.box_max_x = 16'($urandom_range(shadow_src[0]));
            r.box_min_y = 16'($urandom_range(shadow_src[1]));
            r.box_max_y = 16'($urandom_range(shadow_src[1]));
            r.box_min_z = 16'($urandom_range(shadow_src[2]));
            r.box_max_z = 16'($urandom_range(shadow_src[2]));
        end
        if ($urandom_range(3) != 0)
            r.voxel_index = 16'($urandom_range(511));
        return r;
    endfunction

    // Directed rows. Where want_check is set the result is also compared with
    // the typed-in value; all rows are compared with the predictor as well.
    typedef struct {
        in_item_t  req;
        bit        want_check;
        out_item_t want;
    } directed_row_t;

    directed_row_t directed_rows [$];

    task automatic add_row(input in_item_t req, input bit chk, input out_item_t want);
        directed_row_t row;
        row.req = req;
        row.want_check = chk;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic run_directed;
        out_item_t z;
        out_item_t first_hit;
        z = '0;
        first_hit = '0;
        first_hit.bin_count = 16'd1;
        first_hit.peak_count = 16'd1;
        first_hit.normalized_value = 17'd65536;
        first_hit.bin_was_hit = 1'b1;
        // A read of bin 0 right after reset sees an empty grid.
        add_row(make_request(REQ_READ, 1'b0, 0, 0, 0, 0, 0, 0, 16'd0), 1'b1, z);
        // All-zero corners land in bin 0, the first hit gives density 1.0.
        add_row(make_request(REQ_ADD, 1'b1, 0, 0, 0, 0, 0, 0, 0), 1'b1, first_hit);
        add_row(make_request(REQ_ADD, 1'b1, 0, 0, 0, 0, 0, 0, 0), 1'b0, z);
        // Maximum corners clamp each axis to the last bin.
        add_row(make_request(REQ_ADD, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 1'b0, z);
        // An inactive add only reports the peak.
        add_row(make_request(REQ_ADD, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, z);
        // The unused request code changes nothing.
        add_row(make_request(2'd3, 1'b1, 1, 2, 3, 4, 5, 6, 16'hFFFF), 1'b0, z);
        add_row(make_request(REQ_READ, 1'b0, 0, 0, 0, 0, 0, 0, 16'd0), 1'b0, z);
        add_row(make_request(REQ_READ, 1'b1, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b0, z);
        // Swapped corners, centre given as min+max.
        add_row(make_request(REQ_ADD, 1'b1, 900, 900, 200, 100, 100, 10, 0), 1'b0, z);
        add_row(make_request(REQ_ADD, 1'b1, 512, 512, 128, 512, 512, 128, 0), 1'b0, z);
        // A clear returns an all-zero result.
        add_row(make_request(REQ_CLEAR, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, z);
        add_row(make_request(REQ_READ, 1'b0, 0, 0, 0, 0, 0, 0, 16'd0), 1'b1, z);
        foreach (directed_rows[i])
            send_request(directed_rows[i].req);
        release_input();
    endtask

    // Drives a run of random requests.
    task automatic run_random(input int count);
        repeat (count)
            send_request(random_request());
        release_input();
    endtask

    // Receiver: stalls at random, or holds off for a long stretch on request.
    initial
    begin
        int hold_count;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (recv_hold)
            begin
                out_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_OFF; hold_count++)
                    @(negedge clk);
                recv_hold = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Checker: each result transfer is compared with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer: %p", out_data);
                error_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (out_data.bin_index !== e.bin_index)
                begin
                    $error("bin_index: expected %0d, got %0d", e.bin_index, out_data.bin_index);
                    error_count++;
                end
                if (out_data.bin_count !== e.bin_count)
                begin
                    $error("bin_count: expected %0d, got %0d", e.bin_count, out_data.bin_count);
                    error_count++;
                end
                if (out_data.peak_count !== e.peak_count)
                begin
                    $error("peak_count: expected %0d, got %0d",
                           e.peak_count, out_data.peak_count);
                    error_count++;
                end
                if (out_data.normalized_value !== e.normalized_value)
                begin
                    $error("normalized_value: expected %0d, got %0d",
                           e.normalized_value, out_data.normalized_value);
                    error_count++;
                end
                if (out_data.bin_was_hit !== e.bin_was_hit)
                begin
                    $error("bin_was_hit: expected %0d, got %0d",
                           e.bin_was_hit, out_data.bin_was_hit);
                    error_count++;
                end
            end
        end
    end

    // Checks the typed-in expectations of the directed rows against the result
    // stream by watching transfers in order.
    int directed_seen;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && directed_seen < directed_rows.size())
        begin
            if (directed_rows[directed_seen].want_check
                && out_data !== directed_rows[directed_seen].want)
            begin
                $error("directed row %0d: expected %p, got %p",
                       directed_seen, directed_rows[directed_seen].want, out_data);
                error_count++;
            end
            directed_seen++;
        end
    end

    // Watchdog: counts cycles with no transfer on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_GRID_W;
        cfg_data       = '0;
        error_count    = 0;
        idle_cycles    = 0;
        directed_seen  = 0;
        stimulus_done  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 1'b0;
        foreach (shadow_bins[i])
            shadow_bins[i] = 16'd0;
        shadow_peak = 16'd0;
        shadow_grid[0] = 9'd64;
        shadow_grid[1] = 9'd64;
        shadow_grid[2] = 9'd16;
        shadow_src[0] = 16'd1024;
        shadow_src[1] = 16'd1024;
        shadow_src[2] = 16'd256;
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset geometry, with no idling.
        run_directed();

        // Reset geometry, no idling.
        run_random(RANDOM_ITEMS / 6);

        // Sender idles, small grid; a bin fills fast and the peak climbs.
        send_idle_pct = 55;
        set_geometry(2, 2, 1, 100, 100, 100);
        run_random(RANDOM_ITEMS / 6);

        // Receiver stalls, largest grid: many adds fall beyond storage.
        send_idle_pct = 0;
        recv_stall_pct = 55;
        set_geometry(256, 256, 256, 65535, 65535, 65535);
        run_random(RANDOM_ITEMS / 6);

        // Out-of-range registers: zero sizes act as one, oversize grids as 256.
        send_idle_pct = 27;
        recv_stall_pct = 27;
        set_geometry(0, 16'h1FF, 3, 0, 0, 1);
        run_random(RANDOM_ITEMS / 6);

        // Long hold-off by the receiver while the sender keeps offering.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_geometry(16, 8, 4, 1000, 500, 64);
        recv_hold = 1'b1;
        run_random(RANDOM_ITEMS / 6);

        // Random geometry at the end, mixed idling.
        send_idle_pct = 27;
        recv_stall_pct = 27;
        set_geometry(16'($urandom_range(1, 256)), 16'($urandom_range(1, 256)),
                     16'($urandom_range(1, 4)),
                     16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                     16'($urandom_range(1, 65535)));
        run_random(RANDOM_ITEMS / 6);

        wait_drained();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
